// File: src/netstr_pkg.sv
// shared types and constants for the netstring deframer
package netstr_pkg;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 3;
    localparam int unsigned LENGTH_W    = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DIGITS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SKIP_NL    = 1'd1;

    localparam logic [2:0] MAX_DIGITS_RESET = 3'd6;
    localparam logic [2:0] HARD_DIGIT_LIMIT = 3'd6;

    localparam logic [7:0] CHAR_COLON   = 8'h3a;
    localparam logic [7:0] CHAR_COMMA   = 8'h2c;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd1;
    localparam logic [2:0] ERR_LEAD_ZERO = 3'd2;
    localparam logic [2:0] ERR_BAD_CHAR  = 3'd3;
    localparam logic [2:0] ERR_BAD_TAIL  = 3'd4;
    localparam logic [2:0] ERR_MISSING   = 3'd5;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_in_buffer;
    } byte_item_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       string_done;
        logic [2:0] error_code;
    } result_item_t;

endpackage

// File: src/netstring_deframer_core.sv
// netstring deframer top level: byte input register, parser, result register
// Takes one byte per cycle while byte_stall is low and gives exactly one result
// per byte. The byte is held in an input register, the parser state and the
// header length (a 20-bit shift-and-add times ten) are updated by a single level
// of logic, and the result lands in an output register, so a new byte can be
// accepted while a finished result waits to be taken if the input register is
// free. byte_stall rises only when both registers hold a transaction and the
// result side is stalled. Configuration is written through cfg_valid/cfg_ready,
// which is always ready, and must only be written while the block is idle.
module netstring_deframer_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 byte_valid,
    output logic                                 byte_stall,
    input  netstr_pkg::byte_item_t               byte_data,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output netstr_pkg::result_item_t             result_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [netstr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [netstr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [1:0]
    {
        MODE_HEADER,
        MODE_PAYLOAD,
        MODE_TAIL,
        MODE_DISCARD
    } mode_t;

    mode_t                             mode_reg, mode_next;
    logic [2:0]                        digit_count_reg, digit_count_next;
    logic                              lead_zero_reg, lead_zero_next;
    logic [netstr_pkg::LENGTH_W-1:0]   remaining_reg, remaining_next;
    logic                              started_reg, started_next;
    logic [2:0]                        max_digits_reg;
    logic                              skip_nl_reg;
    logic                              stage_valid_reg;
    netstr_pkg::byte_item_t            stage_reg;
    logic                              result_valid_reg;
    netstr_pkg::result_item_t          result_reg, result_next;

    logic                              result_load;
    logic                              advance;
    logic                              stage_load;
    logic [2:0]                        limit;
    logic [7:0]                        digit_diff;
    logic [3:0]                        digit_val;
    logic [netstr_pkg::LENGTH_W-1:0]   times_ten;
    logic [netstr_pkg::LENGTH_W-1:0]   remaining_dec;
    logic [7:0]                        b;

    assign result_load  = !result_valid_reg || !result_stall;
    assign advance      = stage_valid_reg && result_load;
    assign byte_stall   = stage_valid_reg && !result_load;
    assign stage_load   = byte_valid && !byte_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    assign b             = stage_reg.byte_value;
    assign digit_diff    = b - netstr_pkg::CHAR_ZERO;
    assign digit_val     = digit_diff[3:0];
    assign times_ten     = {remaining_reg[netstr_pkg::LENGTH_W-4:0], 3'b000}
                         + {remaining_reg[netstr_pkg::LENGTH_W-2:0], 1'b0}
                         + {{(netstr_pkg::LENGTH_W-4){1'b0}}, digit_val};
    assign remaining_dec = remaining_reg - {{(netstr_pkg::LENGTH_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        limit = max_digits_reg;
        if (limit == 3'd0)
        begin
            limit = 3'd1;
        end
        else if (limit > netstr_pkg::HARD_DIGIT_LIMIT)
        begin
            limit = netstr_pkg::HARD_DIGIT_LIMIT;
        end
    end

    always_comb
    begin
        mode_next        = mode_reg;
        digit_count_next = digit_count_reg;
        lead_zero_next   = lead_zero_reg;
        remaining_next   = remaining_reg;
        started_next     = started_reg;
        result_next      = '0;

        case (mode_reg)
            MODE_HEADER:
            begin
                if (b == netstr_pkg::CHAR_COLON)
                begin
                    digit_count_next = 3'd0;
                    lead_zero_next   = 1'b0;
                    mode_next        = (remaining_reg == '0) ? MODE_TAIL : MODE_PAYLOAD;
                end
                else if (b inside {[netstr_pkg::CHAR_ZERO:netstr_pkg::CHAR_NINE]})
                begin
                    if (digit_count_reg >= limit)
                    begin
                        result_next.error_code = netstr_pkg::ERR_TOO_LONG;
                    end
                    else if (lead_zero_reg)
                    begin
                        result_next.error_code = netstr_pkg::ERR_LEAD_ZERO;
                    end
                    else
                    begin
                        if (digit_count_reg == 3'd0 && b == netstr_pkg::CHAR_ZERO)
                        begin
                            lead_zero_next = 1'b1;
                        end
                        remaining_next   = times_ten;
                        digit_count_next = digit_count_reg + 3'd1;
                    end
                end
                else if (!(b == netstr_pkg::CHAR_NEWLINE && skip_nl_reg))
                begin
                    result_next.error_code = netstr_pkg::ERR_BAD_CHAR;
                end
            end
            MODE_PAYLOAD:
            begin
                result_next.payload_valid = 1'b1;
                result_next.payload_byte  = b;
                started_next              = 1'b1;
                remaining_next            = remaining_dec;
                if (remaining_dec == '0)
                begin
                    mode_next = MODE_TAIL;
                end
            end
            MODE_TAIL:
            begin
                if (b == netstr_pkg::CHAR_COMMA)
                begin
                    result_next.string_done = 1'b1;
                    mode_next               = MODE_HEADER;
                    digit_count_next        = 3'd0;
                    lead_zero_next          = 1'b0;
                    remaining_next          = '0;
                    started_next            = 1'b0;
                end
                else
                begin
                    result_next.error_code = netstr_pkg::ERR_BAD_TAIL;
                end
            end
            default:
            begin
            end
        endcase

        if (result_next.error_code != netstr_pkg::ERR_NONE)
        begin
            mode_next = MODE_DISCARD;
        end
        else if (stage_reg.last_in_buffer && mode_next != MODE_DISCARD && started_next)
        begin
            result_next.error_code = netstr_pkg::ERR_MISSING;
        end

        if (stage_reg.last_in_buffer)
        begin
            mode_next        = MODE_HEADER;
            digit_count_next = 3'd0;
            lead_zero_next   = 1'b0;
            remaining_next   = '0;
            started_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_HEADER;
            digit_count_reg  <= 3'd0;
            lead_zero_reg    <= 1'b0;
            remaining_reg    <= '0;
            started_reg      <= 1'b0;
            max_digits_reg   <= netstr_pkg::MAX_DIGITS_RESET;
            skip_nl_reg      <= 1'b1;
            stage_valid_reg  <= 1'b0;
            stage_reg        <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    netstr_pkg::REG_MAX_DIGITS: max_digits_reg <= cfg_data;
                    netstr_pkg::REG_SKIP_NL:    skip_nl_reg    <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            if (stage_load)
            begin
                stage_reg <= byte_data;
            end
            if (stage_load || advance)
            begin
                stage_valid_reg <= stage_load;
            end

            if (result_load)
            begin
                result_valid_reg <= advance;
            end
            if (advance)
            begin
                result_reg      <= result_next;
                mode_reg        <= mode_next;
                digit_count_reg <= digit_count_next;
                lead_zero_reg   <= lead_zero_next;
                remaining_reg   <= remaining_next;
                started_reg     <= started_next;
            end
        end
    end

    // parser always restarts after the last byte of a buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage_reg.last_in_buffer
        |=> mode_reg == MODE_HEADER && remaining_reg == '0 && !started_reg)
        else $error("parser not cleared after end of buffer");

    // input side only stalls behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> stage_valid_reg && result_valid_reg && result_stall)
        else $error("input stalled without a held result");

    // a payload byte never commits a string or carries a header fault
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.payload_valid
        |-> !result_data.string_done
            && (result_data.error_code == netstr_pkg::ERR_NONE
                || result_data.error_code == netstr_pkg::ERR_MISSING))
        else $error("payload byte with commit or header fault");

    // header digit count stays within the hard limit
    assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= netstr_pkg::HARD_DIGIT_LIMIT)
        else $error("digit count beyond limit");

endmodule
